// File: hw/rtl/wsps_pkg.sv
// shared types and constants of the weighted score priority sort
`default_nettype none
package wsps_pkg;
	localparam int unsigned VW = 10;
	localparam int unsigned SW = 12;
	localparam int unsigned RW = 23;
	localparam int unsigned NDIV = 4;
	localparam int unsigned STW = 4;

	localparam logic [1:0] REG_MIN_EXEC = 2'd0;
	localparam logic [1:0] REG_MIN_RAM = 2'd1;
	localparam logic [1:0] REG_MIN_PROC = 2'd2;
	localparam logic [1:0] REG_MIN_BW = 2'd3;

	localparam logic [RW-1:0] RANK_TOP = {1'b1, {(RW-1){1'b0}}};

	typedef struct packed {
		logic [VW-1:0] id;
		logic [VW-1:0] eq;
		logic [SW-1:0] score;
		logic          last;
	} rec_t;

	typedef struct packed {
		logic [RW-1:0] rank;
		logic [VW-1:0] id;
	} entry_t;
endpackage
`default_nettype wire

// File: hw/rtl/wsps_front.sv
// front: accepts records, holds divisors, divides attributes by their minima
`default_nettype none
module wsps_front (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_valid,
	input  wire logic [1:0]           cfg_index,
	input  wire logic [wsps_pkg::VW-1:0] cfg_data,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [wsps_pkg::VW-1:0] task_id,
	input  wire logic [wsps_pkg::VW-1:0] exec_time,
	input  wire logic [wsps_pkg::VW-1:0] ram_ratio,
	input  wire logic [wsps_pkg::VW-1:0] proc_ratio,
	input  wire logic [wsps_pkg::VW-1:0] bw_ratio,
	input  wire logic                 last_task,
	output logic                      push,
	output wsps_pkg::rec_t            push_rec,
	input  wire logic                 full
);
	localparam logic [1:0] F_IDLE = 2'd0;
	localparam logic [1:0] F_DIV = 2'd1;
	localparam logic [1:0] F_PUSH = 2'd2;
	localparam int unsigned VW = wsps_pkg::VW;
	localparam int unsigned ND = wsps_pkg::NDIV;

	logic [VW-1:0] min_q [ND];
	logic [VW-1:0] div_q [ND];
	logic [VW:0]   rem_q [ND];
	logic [VW-1:0] dq_q [ND];
	logic [VW:0]   rem_nx [ND];
	logic [VW-1:0] dq_nx [ND];
	logic [VW-1:0] attr [ND];
	logic [VW-1:0] id_q;
	logic          last_q;
	logic [1:0]    state_q;
	logic [wsps_pkg::STW-1:0] step_q;
	logic [VW:0]   trial [ND];

	assign attr[0] = exec_time;
	assign attr[1] = ram_ratio;
	assign attr[2] = proc_ratio;
	assign attr[3] = bw_ratio;

	assign in_stall = (state_q != F_IDLE);
	assign push = (state_q == F_PUSH) && !full;

	always_comb begin
		push_rec.id = id_q;
		push_rec.eq = dq_q[0];
		push_rec.score = wsps_pkg::SW'(dq_q[1]) + wsps_pkg::SW'(dq_q[2])
			+ wsps_pkg::SW'(dq_q[3]);
		push_rec.last = last_q;
	end

	// one restoring step per lane
	always_comb begin
		for (int k = 0; k < ND; k++) begin
			trial[k] = {rem_q[k][VW-1:0], dq_q[k][VW-1]};
			if (trial[k] >= {1'b0, div_q[k]}) begin
				rem_nx[k] = trial[k] - {1'b0, div_q[k]};
				dq_nx[k] = {dq_q[k][VW-2:0], 1'b1};
			end else begin
				rem_nx[k] = trial[k];
				dq_nx[k] = {dq_q[k][VW-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < ND; k++) min_q[k] <= VW'(1);
		end else if (cfg_valid) begin
			case (cfg_index)
				wsps_pkg::REG_MIN_EXEC: min_q[0] <= cfg_data;
				wsps_pkg::REG_MIN_RAM: min_q[1] <= cfg_data;
				wsps_pkg::REG_MIN_PROC: min_q[2] <= cfg_data;
				wsps_pkg::REG_MIN_BW: min_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			step_q <= '0;
		end else begin
			case (state_q)
				F_IDLE: if (in_valid) begin
					state_q <= F_DIV;
					step_q <= '0;
				end
				F_DIV: begin
					step_q <= step_q + 1'b1;
					if (step_q == wsps_pkg::STW'(VW - 1)) state_q <= F_PUSH;
				end
				F_PUSH: if (!full) state_q <= F_IDLE;
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && in_valid) begin
			id_q <= task_id;
			last_q <= last_task;
			for (int k = 0; k < ND; k++) begin
				div_q[k] <= (min_q[k] == '0) ? VW'(1) : min_q[k];
				rem_q[k] <= '0;
				dq_q[k] <= attr[k];
			end
		end else if (state_q == F_DIV) begin
			for (int k = 0; k < ND; k++) begin
				rem_q[k] <= rem_nx[k];
				dq_q[k] <= dq_nx[k];
			end
		end
	end
endmodule
`default_nettype wire

// File: hw/rtl/wsps_fifo.sv
// two-entry record queue between front and back
`default_nettype none
module wsps_fifo (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire wsps_pkg::rec_t push_rec,
	output logic                full,
	input  wire logic           pop,
	output wsps_pkg::rec_t      pop_rec,
	output logic                empty
);
	wsps_pkg::rec_t ent_q [2];
	logic wp_q;
	logic rp_q;
	logic [1:0] cnt_q;

	assign full = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign pop_rec = ent_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) ent_q[wp_q] <= push_rec;
	end
endmodule
`default_nettype wire

// File: hw/rtl/wsps_back.sv
// back: stores ranked records and emits ids by repeated max scans
`default_nettype none
module wsps_back #(
	parameter int unsigned MAX_TASKS = 64
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           empty,
	input  wire wsps_pkg::rec_t pop_rec,
	output logic                pop,
	output logic                out_valid,
	input  wire logic           out_stall,
	output logic [wsps_pkg::VW-1:0] sorted_id,
	output logic                last_out
);
	localparam int unsigned IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int unsigned CW = $clog2(MAX_TASKS + 1);
	localparam logic [1:0] B_IDLE = 2'd0;
	localparam logic [1:0] B_SCAN = 2'd1;
	localparam logic [1:0] B_EMIT = 2'd2;

	wsps_pkg::entry_t mem_q [MAX_TASKS];
	wsps_pkg::entry_t rd_s1;
	wsps_pkg::entry_t wr_ent;
	logic [MAX_TASKS-1:0] done_q;
	logic [1:0]    state_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] cnt_nx;
	logic [CW-1:0] scan_q;
	logic [CW-1:0] emit_q;
	logic [IW-1:0] idx_s1;
	logic          vld_s1;
	logic          found_q;
	logic [wsps_pkg::RW-1:0] best_rank_q;
	logic [IW-1:0] best_idx_q;
	logic [wsps_pkg::VW-1:0] best_id_q;
	logic          store_ok;
	logic          rd_en;
	logic          emit_last;

	assign pop = (state_q == B_IDLE) && !empty;
	assign store_ok = (cnt_q < CW'(MAX_TASKS));
	assign cnt_nx = (pop && store_ok) ? cnt_q + 1'b1 : cnt_q;
	assign rd_en = (state_q == B_SCAN) && (scan_q < cnt_q);
	assign out_valid = (state_q == B_EMIT);
	assign sorted_id = best_id_q;
	assign emit_last = (CW'(emit_q + 1'b1) == cnt_q);
	assign last_out = emit_last;

	always_comb begin
		wr_ent.id = pop_rec.id;
		if (pop_rec.eq == '0) wr_ent.rank = wsps_pkg::RANK_TOP;
		else wr_ent.rank = {1'b0, pop_rec.score, ~pop_rec.eq};
	end

	always_ff @(posedge clk) begin
		if (pop && store_ok) mem_q[cnt_q[IW-1:0]] <= wr_ent;
		if (rd_en) rd_s1 <= mem_q[scan_q[IW-1:0]];
		if (rd_en) idx_s1 <= scan_q[IW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			cnt_q <= '0;
			scan_q <= '0;
			emit_q <= '0;
			vld_s1 <= 1'b0;
			found_q <= 1'b0;
			done_q <= '0;
			best_rank_q <= '0;
			best_idx_q <= '0;
			best_id_q <= '0;
		end else begin
			vld_s1 <= rd_en;
			case (state_q)
				B_IDLE: if (pop) begin
					cnt_q <= cnt_nx;
					if (pop_rec.last && cnt_nx != '0) begin
						state_q <= B_SCAN;
						scan_q <= '0;
						emit_q <= '0;
						found_q <= 1'b0;
					end
				end
				B_SCAN: begin
					if (rd_en) scan_q <= scan_q + 1'b1;
					if (vld_s1 && !done_q[idx_s1]
						&& (!found_q || rd_s1.rank > best_rank_q)) begin
						found_q <= 1'b1;
						best_rank_q <= rd_s1.rank;
						best_idx_q <= idx_s1;
						best_id_q <= rd_s1.id;
					end
					if (!rd_en && !vld_s1) state_q <= B_EMIT;
				end
				B_EMIT: if (!out_stall) begin
					if (emit_last) begin
						cnt_q <= '0;
						done_q <= '0;
						state_q <= B_IDLE;
					end else begin
						done_q[best_idx_q] <= 1'b1;
						emit_q <= emit_q + 1'b1;
						scan_q <= '0;
						found_q <= 1'b0;
						state_q <= B_SCAN;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_emit_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> cnt_q != '0)
		else $error("emit with empty store");
	a_emit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> emit_q < cnt_q)
		else $error("emit count past store count");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_TASKS))
		else $error("store count overflow");
	a_scan_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != B_IDLE) |-> !pop)
		else $error("queue popped during sort");
`endif
endmodule
`default_nettype wire

// File: hw/rtl/weighted_score_priority_sort.sv
// top level of the weighted score priority sort
`default_nettype none
// Loads task records one transaction at a time; each record passes through the
// front, where four 10-step restoring dividers run in parallel, then goes
// through a two-entry queue to the back, which stores it while idle. On a
// record marked last the back emits all stored ids in descending rank, each
// found by a scan over the store through its single read port.
// Configuration writes are always ready and apply to records accepted later.
module weighted_score_priority_sort #(
	parameter int unsigned MAX_TASKS = 64
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_valid,
	output logic                          cfg_ready,
	input  wire logic [1:0]               cfg_index,
	input  wire logic [wsps_pkg::VW-1:0]  cfg_data,
	input  wire logic                     in_valid,
	output logic                          in_stall,
	input  wire logic [wsps_pkg::VW-1:0]  task_id,
	input  wire logic [wsps_pkg::VW-1:0]  exec_time,
	input  wire logic [wsps_pkg::VW-1:0]  ram_ratio,
	input  wire logic [wsps_pkg::VW-1:0]  proc_ratio,
	input  wire logic [wsps_pkg::VW-1:0]  bw_ratio,
	input  wire logic                     last_task,
	output logic                          out_valid,
	input  wire logic                     out_stall,
	output logic [wsps_pkg::VW-1:0]       sorted_id,
	output logic                          last_out
);
	logic push;
	logic full;
	logic pop;
	logic empty;
	wsps_pkg::rec_t push_rec;
	wsps_pkg::rec_t pop_rec;

	assign cfg_ready = 1'b1;

	wsps_front u_front (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.task_id(task_id), .exec_time(exec_time), .ram_ratio(ram_ratio),
		.proc_ratio(proc_ratio), .bw_ratio(bw_ratio), .last_task(last_task),
		.push(push), .push_rec(push_rec), .full(full)
	);

	wsps_fifo u_fifo (
		.clk(clk), .arst_n(arst_n),
		.push(push), .push_rec(push_rec), .full(full),
		.pop(pop), .pop_rec(pop_rec), .empty(empty)
	);

	wsps_back #(.MAX_TASKS(MAX_TASKS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.empty(empty), .pop_rec(pop_rec), .pop(pop),
		.out_valid(out_valid), .out_stall(out_stall),
		.sorted_id(sorted_id), .last_out(last_out)
	);
endmodule
`default_nettype wire

// File: sim/weighted_score_priority_sort_test.sv
// testbench for the weighted score priority sort: directed and random batches checked against a scoring model
`default_nettype none
module weighted_score_priority_sort_test;
	localparam int unsigned MAX_TASKS = 64;
	localparam int unsigned VW = wsps_pkg::VW;
	localparam int unsigned SW = wsps_pkg::SW;
	localparam int unsigned RW = wsps_pkg::RW;

	typedef struct packed {
		logic [VW-1:0] id;
		logic [VW-1:0] ex;
		logic [VW-1:0] ram;
		logic [VW-1:0] proc;
		logic [VW-1:0] bw;
		logic          last;
	} task_t;

	typedef struct packed {
		logic [VW-1:0] id;
		logic [VW-1:0] eq;
		logic [SW-1:0] score;
	} scored_t;

	typedef struct packed {
		logic [VW-1:0] id;
		logic          last;
	} order_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = wsps_pkg::REG_MIN_EXEC;
	logic [VW-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic in_taken = 1'b0;
	logic [VW-1:0] task_id = '0, exec_time = '0, ram_ratio = '0, proc_ratio = '0, bw_ratio = '0;
	logic last_task = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [VW-1:0] sorted_id;
	logic last_out;

	task_t pending_tasks[$];
	scored_t loaded_records[$];
	order_t due_order[$];
	logic [VW-1:0] div_reg[4] = '{VW'(1), VW'(1), VW'(1), VW'(1)};
	int errors = 0;
	int gap_left = 0;
	int burst_left = 0;
	int stall_mode = 0;
	int stall_cnt = 0;

	weighted_score_priority_sort #(.MAX_TASKS(MAX_TASKS)) DUT (.*);

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("weighted_score_priority_sort_test failed");
		$finish;
	end

	task automatic report(input string msg);
		$display("mismatch at %0t: %s", $time, msg);
		errors++;
	endtask

	function automatic logic [VW-1:0] divide(input logic [VW-1:0] v, input logic [VW-1:0] d);
		logic [VW-1:0] dv;
		dv = (d == '0) ? VW'(1) : d;
		return v / dv;
	endfunction

	function automatic logic [RW-1:0] priority_of(input scored_t r);
		if (r.eq == '0)
			return wsps_pkg::RANK_TOP;
		return {1'b0, r.score, ~r.eq};
	endfunction

	// score the record and, on the last of a batch, queue the ids in rank order
	task automatic score_task(input task_t t);
		scored_t r;
		scored_t ranked[$];
		order_t o;
		int j;
		if (loaded_records.size() < MAX_TASKS) begin
			r.id = t.id;
			r.eq = divide(t.ex, div_reg[wsps_pkg::REG_MIN_EXEC]);
			r.score = SW'(divide(t.ram, div_reg[wsps_pkg::REG_MIN_RAM])) +
				SW'(divide(t.proc, div_reg[wsps_pkg::REG_MIN_PROC])) +
				SW'(divide(t.bw, div_reg[wsps_pkg::REG_MIN_BW]));
			loaded_records.insert(loaded_records.size(), r);
		end
		if (!t.last)
			return;
		foreach (loaded_records[i]) begin
			j = ranked.size();
			while (j > 0 && priority_of(ranked[j-1]) < priority_of(loaded_records[i]))
				j--;
			ranked.insert(j, loaded_records[i]);
		end
		foreach (ranked[i]) begin
			o.id = ranked[i].id;
			o.last = (i == ranked.size() - 1);
			due_order.insert(due_order.size(), o);
		end
		loaded_records.delete();
	endtask

	// driver: bursts of transactions separated by random gaps, plus random output stalls
	always @(negedge clk) begin
		if (!in_valid || in_taken) begin
			if (burst_left == 0 && gap_left == 0) begin
				burst_left = $urandom_range(1, 12);
				gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
			end
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (pending_tasks.size() > 0) begin
				task_t t;
				t = pending_tasks.pop_front();
				burst_left--;
				in_valid <= 1'b1;
				task_id <= t.id;
				exec_time <= t.ex;
				ram_ratio <= t.ram;
				proc_ratio <= t.proc;
				bw_ratio <= t.bw;
				last_task <= t.last;
			end else begin
				in_valid <= 1'b0;
			end
		end
		if (stall_cnt == 0) begin
			stall_cnt = $urandom_range(8, 80);
			stall_mode = $urandom_range(0, 2);
		end
		stall_cnt--;
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			default: out_stall <= ($urandom_range(0, 3) != 0);
		endcase
	end

	always @(posedge clk) begin
		in_taken <= in_valid && !in_stall;
		if (in_valid && !in_stall)
			score_task('{task_id, exec_time, ram_ratio, proc_ratio, bw_ratio, last_task});
	end

	// monitor
	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			order_t e;
			if (due_order.size() == 0) begin
				report($sformatf("unexpected id %0d", sorted_id));
			end else begin
				e = due_order.pop_front();
				if (sorted_id !== e.id)
					report($sformatf("sorted_id %0d, wanted %0d", sorted_id, e.id));
				if (last_out !== e.last)
					report($sformatf("last_out %0b, wanted %0b", last_out, e.last));
			end
		end
	end

	task automatic write_reg(input logic [1:0] idx, input logic [VW-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		div_reg[idx] = val;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_divisors(input logic [VW-1:0] e, r, p, b);
		write_reg(wsps_pkg::REG_MIN_EXEC, e);
		write_reg(wsps_pkg::REG_MIN_RAM, r);
		write_reg(wsps_pkg::REG_MIN_PROC, p);
		write_reg(wsps_pkg::REG_MIN_BW, b);
	endtask

	task automatic add_task(input logic [VW-1:0] id, ex, ram, proc, bw, input logic last);
		task_t t;
		t = '{id, ex, ram, proc, bw, last};
		pending_tasks.insert(pending_tasks.size(), t);
	endtask

	task automatic add_batch(input int n);
		for (int i = 0; i < n; i++)
			add_task(VW'($urandom_range(0, 1023)), VW'($urandom_range(1, 1023)),
				VW'($urandom_range(1, 1023)), VW'($urandom_range(1, 1023)),
				VW'($urandom_range(1, 1023)), i == n - 1);
	endtask

	task automatic wait_idle();
		while (pending_tasks.size() > 0 || in_valid || due_order.size() > 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	function automatic logic [VW-1:0] pick_divisor();
		case ($urandom_range(0, 4))
			0: return VW'(1);
			1: return VW'(0);
			2: return VW'($urandom_range(1, 16));
			3: return VW'($urandom_range(200, 600));
			default: return VW'($urandom_range(1, 1023));
		endcase
	endfunction

	initial begin
		int n;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset divisors: extremes, equal scores, stable order
		add_task(10'd0, 10'd1, 10'd1023, 10'd1023, 10'd1023, 1'b0);
		add_task(10'd1023, 10'd1023, 10'd1, 10'd1, 10'd1, 1'b0);
		add_task(10'd5, 10'd2, 10'd100, 10'd100, 10'd100, 1'b0);
		add_task(10'd6, 10'd3, 10'd100, 10'd100, 10'd100, 1'b0);
		add_task(10'd7, 10'd2, 10'd150, 10'd50, 10'd100, 1'b0);
		add_task(10'd682, 10'd341, 10'd682, 10'd341, 10'd682, 1'b1);
		add_task(10'd341, 10'd512, 10'd512, 10'd512, 10'd512, 1'b1);
		wait_idle();

		// zero divisor acts as one
		set_divisors(10'd0, 10'd0, 10'd0, 10'd0);
		add_task(10'd1, 10'd9, 10'd3, 10'd3, 10'd3, 1'b0);
		add_task(10'd2, 10'd8, 10'd3, 10'd3, 10'd3, 1'b0);
		add_task(10'd3, 10'd1023, 10'd1023, 10'd1, 10'd1, 1'b1);
		wait_idle();

		// attributes below minimum: zero execution quotient ranks on top
		set_divisors(10'd1023, 10'd1023, 10'd1023, 10'd1023);
		add_task(10'd11, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 1'b0);
		add_task(10'd12, 10'd500, 10'd1, 10'd1, 10'd1, 1'b0);
		add_task(10'd13, 10'd1022, 10'd1023, 10'd1023, 10'd1023, 1'b0);
		add_task(10'd14, 10'd1023, 10'd1022, 10'd1023, 10'd1023, 1'b0);
		add_task(10'd15, 10'd1, 10'd1023, 10'd1023, 10'd1023, 1'b1);
		wait_idle();

		// full store plus dropped records
		set_divisors(10'd300, 10'd400, 10'd250, 10'd500);
		add_batch(MAX_TASKS + 3);
		wait_idle();

		for (int ph = 0; ph < 8; ph++) begin
			set_divisors(pick_divisor(), pick_divisor(), pick_divisor(), pick_divisor());
			for (int b = 0; b < 4; b++) begin
				n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 5);
				add_batch(n);
			end
			wait_idle();
		end

		if (errors == 0)
			$display("weighted_score_priority_sort_test passed");
		else
			$display("weighted_score_priority_sort_test failed");
		$finish;
	end
endmodule
`default_nettype wire

// File: files.f
hw/rtl/wsps_pkg.sv
hw/rtl/wsps_front.sv
hw/rtl/wsps_fifo.sv
hw/rtl/wsps_back.sv
hw/rtl/weighted_score_priority_sort.sv
sim/weighted_score_priority_sort_test.sv
